// File: rtl/mmng_pkg.sv
// Shared types and constants for the min-max normalize-to-gray unit.
// No dependencies; used by mmng_range, mmng_div and the top level.
`timescale 1ns / 1ps

package mmng_pkg;

    localparam int unsigned ELEV_W = 16;
    localparam int unsigned GRAY_W = 8;

    localparam logic signed [ELEV_W-1:0] ELEV_MAX     = 16'sh7FFF;
    localparam logic signed [ELEV_W-1:0] ELEV_MIN     = 16'sh8000;
    localparam logic        [GRAY_W-1:0] GRAY_FULL    = 8'hFF;
    localparam logic        [GRAY_W-1:0] GRAY_ZERO    = 8'h00;
    localparam logic signed [ELEV_W-1:0] NO_DATA_RST  = 16'sh8000;

    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_MAP  = 1'b1;

    // Strobes from the top level to the range tracker
    typedef struct packed {
        logic scan;   // scan word accepted this cycle
        logic map;    // map word accepted this cycle
        logic last;   // last mark of the accepted word
    } t_range_ctl;

endpackage

// File: rtl/mmng_range.sv
// Running minimum / maximum tracker for the scan pass.
// Depends on mmng_pkg (widths, constants, t_range_ctl).
`timescale 1ns / 1ps

module mmng_range (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mmng_pkg::t_range_ctl                 i_ctl,
    input  logic signed [mmng_pkg::ELEV_W-1:0]   i_elev,
    input  logic signed [mmng_pkg::ELEV_W-1:0]   i_no_data,
    output logic signed [mmng_pkg::ELEV_W-1:0]   o_min,
    output logic signed [mmng_pkg::ELEV_W-1:0]   o_max
);

    logic signed [mmng_pkg::ELEV_W-1:0] r_min, n_min;
    logic signed [mmng_pkg::ELEV_W-1:0] r_max, n_max;
    logic                               r_scan_done, n_scan_done;
    logic signed [mmng_pkg::ELEV_W-1:0] base_min, base_max;

    // Restart the range on the first scan word after a finished pass
    always_comb begin
        base_min    = r_scan_done ? mmng_pkg::ELEV_MAX : r_min;
        base_max    = r_scan_done ? mmng_pkg::ELEV_MIN : r_max;
        n_min       = r_min;
        n_max       = r_max;
        n_scan_done = r_scan_done;
        if (i_ctl.scan) begin
            n_min       = base_min;
            n_max       = base_max;
            n_scan_done = i_ctl.last;
            if (i_elev != i_no_data) begin
                if (i_elev < base_min) n_min = i_elev;
                if (i_elev > base_max) n_max = i_elev;
            end
        end else if (i_ctl.map) begin
            n_scan_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= mmng_pkg::ELEV_MAX;
            r_max       <= mmng_pkg::ELEV_MIN;
            r_scan_done <= 1'b1;
        end else begin
            r_min       <= n_min;
            r_max       <= n_max;
            r_scan_done <= n_scan_done;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

// File: rtl/mmng_div.sv
// Bit-serial restoring divider: floor(255*num/den), one quotient bit per cycle.
// Depends on mmng_pkg (widths). Requires num < den so the quotient fits 8 bits.
`timescale 1ns / 1ps

module mmng_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mmng_pkg::ELEV_W-1:0]   i_num,
    input  logic [mmng_pkg::ELEV_W-1:0]   i_den,
    output logic                          o_done,
    output logic [mmng_pkg::GRAY_W-1:0]   o_quot
);

    localparam int unsigned PROD_W = mmng_pkg::ELEV_W + mmng_pkg::GRAY_W;
    localparam int unsigned CNT_W  = $clog2(mmng_pkg::GRAY_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mmng_pkg::GRAY_W - 1);

    logic [mmng_pkg::ELEV_W-1:0] r_rem;
    logic [mmng_pkg::ELEV_W-1:0] r_den;
    logic [mmng_pkg::GRAY_W-1:0] r_low;   // dividend low byte in, quotient bits out
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [PROD_W-1:0]           prod;
    logic [mmng_pkg::ELEV_W:0]   trial;
    logic [mmng_pkg::ELEV_W:0]   diff;
    logic                        qbit;

    // 255*num as (num << 8) - num
    assign prod = {i_num, {mmng_pkg::GRAY_W{1'b0}}} - {{mmng_pkg::GRAY_W{1'b0}}, i_num};

    // One restoring step: bring down next dividend bit, try subtract
    assign trial = {r_rem, r_low[mmng_pkg::GRAY_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign qbit  = (trial >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= prod[PROD_W-1:mmng_pkg::GRAY_W];
            r_low <= prod[mmng_pkg::GRAY_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[mmng_pkg::ELEV_W-1:0] : trial[mmng_pkg::ELEV_W-1:0];
            r_low <= {r_low[mmng_pkg::GRAY_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

// File: rtl/min_max_normalize_to_gray_unit.sv
// Top level of the min-max normalize-to-gray unit: handshakes, control, result register.
// Depends on mmng_pkg, mmng_range and mmng_div.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_kind, i_elevation, i_last
//  out     | output    | o_out_valid / i_out_ready    | o_gray, o_flat, o_last_out
//  cfg     | input     | i_cfg_we (no wait)           | i_cfg_data (no-data code)
//
// A scan word updates min/max on its accept edge.
// A map word passes through S_SETUP, the bit-serial divider and a load of the result
// register; the next word is accepted only once the unit is back in S_IDLE.
// Reset is synchronous, active low; it restores the empty range and no-data code.
// A result waiting in the output register does not stop input; a later map result
// that finds it still full waits in S_HOLD, which stalls all input until it drains.
`timescale 1ns / 1ps

module min_max_normalize_to_gray_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic signed [mmng_pkg::ELEV_W-1:0]   i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic signed [mmng_pkg::ELEV_W-1:0]   i_elevation,
    input  logic                                 i_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic        [mmng_pkg::GRAY_W-1:0]   o_gray,
    output logic                                 o_flat,
    output logic                                 o_last_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                             r_state;
    logic signed [mmng_pkg::ELEV_W-1:0] r_no_data;
    logic signed [mmng_pkg::ELEV_W-1:0] r_v;
    logic                               r_last;
    logic                               r_zero;
    logic                               r_full;
    logic                               r_flat;
    logic        [mmng_pkg::GRAY_W-1:0] r_hold_gray;
    logic                               r_out_valid;
    logic        [mmng_pkg::GRAY_W-1:0] r_gray;
    logic                               r_flat_out;
    logic                               r_last_out;

    logic                               in_acc;
    logic                               out_free;
    logic                               res_load;
    mmng_pkg::t_range_ctl               range_ctl;
    logic signed [mmng_pkg::ELEV_W-1:0] range_min, range_max;
    logic        [mmng_pkg::ELEV_W-1:0] num, den;
    logic                               div_start, div_done;
    logic        [mmng_pkg::GRAY_W-1:0] div_quot;
    logic        [mmng_pkg::GRAY_W-1:0] res_gray;
    logic                               set_flat, set_zero, set_full;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Result register takes a finished word when it is empty or being read
    assign res_load   = out_free && ((r_state == S_DIV && div_done) || (r_state == S_HOLD));

    assign range_ctl.scan = in_acc && (i_kind == mmng_pkg::KIND_SCAN);
    assign range_ctl.map  = in_acc && (i_kind == mmng_pkg::KIND_MAP);
    assign range_ctl.last = i_last;

    mmng_range u_range (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (range_ctl),
        .i_elev    (i_elevation),
        .i_no_data (r_no_data),
        .o_min     (range_min),
        .o_max     (range_max)
    );

    // Set-up: classify the sample and form the divider operands
    assign set_flat  = (range_max <= range_min);
    assign set_zero  = set_flat || (r_v == r_no_data) || (r_v <= range_min);
    assign set_full  = (r_v >= range_max);
    assign num       = r_v - range_min;
    assign den       = range_max - range_min;
    assign div_start = (r_state == S_SETUP);

    mmng_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Final gray level with the special cases folded in
    always_comb begin
        priority if (r_zero) res_gray = mmng_pkg::GRAY_ZERO;
        else if (r_full)     res_gray = mmng_pkg::GRAY_FULL;
        else                 res_gray = div_quot;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_data <= mmng_pkg::NO_DATA_RST;
        end else if (i_cfg_we) begin
            r_no_data <= i_cfg_data;
        end
    end

    // Map word capture and classification flags
    always_ff @(posedge i_clk) begin
        if (range_ctl.map) begin
            r_v    <= i_elevation;
            r_last <= i_last;
        end
        if (r_state == S_SETUP) begin
            r_zero <= set_zero;
            r_full <= set_full;
            r_flat <= set_flat;
        end
        if (r_state == S_DIV && div_done) begin
            r_hold_gray <= res_gray;
        end
    end

    // Control FSM and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (res_load)         r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (range_ctl.map) r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (out_free) begin
                            r_gray      <= res_gray;
                            r_flat_out  <= r_flat;
                            r_last_out  <= r_last;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_gray      <= r_hold_gray;
                        r_flat_out  <= r_flat;
                        r_last_out  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gray      = r_gray;
    assign o_flat      = r_flat_out;
    assign o_last_out  = r_last_out;

endmodule
